>>> src/scm_pkg.sv
// Shared widths, fixed-point constants and lane types for the sine/cosine
// pipeline. Used by scm_step and sine_cosine_minimax; depends on nothing.
package scm_pkg;

	localparam int AngW   = 32;  // angle, signed Q8.24
	localparam int OutW   = 32;  // sine and cosine, signed Q2.30
	localparam int MagW   = 32;  // magnitude of a Horner lane value
	localparam int XW     = 32;  // Horner multiplier operand (y squared or |y|)
	localparam int ProdW  = MagW + XW;
	localparam int HornerSteps = 5;

	// Reduction constants
	localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
	localparam logic [30:0] TWO_PI_Q28     = 31'd1686629713;
	localparam logic signed [31:0] PI_Q28      = 32'sd843314857;
	localparam logic signed [31:0] HALF_PI_Q28 = 32'sd421657428;
	localparam logic [MagW-1:0] Q30_ONE = MagW'(32'd1073741824);

	typedef logic signed [31:0] coef_t;

	// Sign-magnitude value carried along a Horner lane
	typedef struct packed {
		logic            neg;
		logic [MagW-1:0] mag;
	} lane_t;

	// Leading coefficients, both negative
	localparam logic [MagW-1:0] SIN_C11_MAG = MagW'(32'd26);
	localparam logic [MagW-1:0] COS_C10_MAG = MagW'(32'd280);

	// Coefficients added after each Horner multiply, highest degree first
	localparam coef_t SIN_COEF [HornerSteps] = '{
		32'sd2956, -32'sd213040, 32'sd8947846, -32'sd178956974, 32'sd1073741824
	};
	localparam coef_t COS_COEF [HornerSteps] = '{
		32'sd26586, -32'sd1491253, 32'sd44739212, -32'sd536870912, 32'sd1073741824
	};

endpackage

>>> src/scm_step.sv
// One Horner step in two pipeline stages: Q30 multiply on magnitudes, then
// round half away from zero, apply sign and add the coefficient. Uses scm_pkg.
module scm_step (
	input  logic                  clk,
	input  logic                  en,
	input  scm_pkg::lane_t        lane_in,
	input  logic [scm_pkg::XW-1:0] x_in,
	input  scm_pkg::coef_t        coef,
	output scm_pkg::lane_t        lane_out
);
	import scm_pkg::*;

	localparam int RW = ProdW - 29;  // rounded product width
	localparam int VW = RW + 2;      // signed sum width
	localparam logic [ProdW:0] RND_HALF = (ProdW + 1)'(1) << 29;

	logic [ProdW-1:0] prod_s1;
	logic             neg_s1;
	lane_t            lane_s2;

	logic [ProdW:0]        rnd;
	logic [RW-1:0]         r;
	logic signed [VW-1:0]  rs;
	logic signed [VW-1:0]  cv;
	logic signed [VW-1:0]  v;
	logic signed [VW-1:0]  absv;

	// Multiply magnitudes
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= ProdW'(lane_in.mag) * ProdW'(x_in);
			neg_s1  <= lane_in.neg;
		end
	end

	// Round, restore sign, add coefficient, split into sign and magnitude
	always_comb begin
		rnd  = {1'b0, prod_s1} + RND_HALF;
		r    = rnd[ProdW:30];
		rs   = $signed({2'b00, r});
		cv   = VW'(coef);
		v    = neg_s1 ? (cv - rs) : (cv + rs);
		absv = v[VW-1] ? -v : v;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_s2.neg <= v[VW-1];
			lane_s2.mag <= MagW'(absv);
		end
	end

	assign lane_out = lane_s2;

endmodule

>>> src/sine_cosine_minimax.sv
// Top level of the sine/cosine pipeline: range reduction, fold, y squared,
// two Horner lanes built from scm_step, saturation. Uses scm_pkg and scm_step.
//
// Usage:
//   Requests enter on the s_axis channel, one angle per request (signed Q8.24
//   radians in s_axis_tdata). Each request yields exactly one result on the
//   m_axis channel: sine in the low 32 bits and cosine in the high 32 bits of
//   m_axis_tdata, both signed Q2.30 and limited to plus or minus one.
//   Throughput is one request per cycle while the receiver keeps up: the
//   pipeline is twenty register stages deep, each holding at most one 32 by
//   32 multiply or one wide add chain, and every stage advances together.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and s_axis_tready drops; nothing is dropped or repeated, and a waiting
//   result does not block a new request while the output register is empty.
//   Reset (arst_n low) clears every valid bit at once; the block takes
//   requests from the first cycle after reset is released.
module sine_cosine_minimax (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] angle
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata    // [31:0] sine, [63:32] cosine
);
	import scm_pkg::*;

	localparam int NumStages  = 20;
	localparam int HornerBase = 7;   // stage where y squared is ready
	localparam int LaneDone   = HornerBase + 2 * HornerSteps;  // Horner lanes done
	localparam int FinalStage = LaneDone + 2;

	typedef struct packed {
		logic            flip;
		logic            yneg;
		logic [MagW-1:0] ymag;
	} side_t;

	logic en;
	logic vld_s [1:NumStages];

	logic signed [AngW-1:0] a_s1, a_s2;
	logic [AngW-1:0]        amag_s1;
	logic [61:0]            qprod_s2;
	logic signed [31:0]     y_s3;
	logic signed [31:0]     yf_s4;
	logic                   flip_s4;
	side_t                  side_s [5:FinalStage];
	logic [ProdW-1:0]       sq_s6;
	logic [XW-1:0]          y2_s [HornerBase:LaneDone-2];
	lane_t                  cos_s18, cos_s19;
	logic [OutW-1:0]        sine_s20, cosine_s20;

	lane_t sin_l [HornerSteps+1];
	lane_t cos_l [HornerSteps+1];
	lane_t sfin_in, sfin_out;

	logic [AngW-1:0]        amag_in;
	logic [62:0]            qrnd;
	logic [6:0]             qm;
	logic [37:0]            qtp;
	logic signed [38:0]     a16;
	logic signed [38:0]     yw;
	logic signed [31:0]     yfold;
	logic                   fold;
	logic signed [31:0]     y30;
	logic [ProdW:0]         sqrnd;
	logic [MagW-1:0]        smag, cmag;
	logic                   cneg;

	// Advance the whole pipeline unless a result is stuck at the output
	assign en            = ~vld_s[NumStages] | m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_s[NumStages];
	assign m_axis_tdata  = {cosine_s20, sine_s20};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= NumStages; i++) vld_s[i] <= 1'b0;
		end else if (en) begin
			vld_s[1] <= s_axis_tvalid;
			for (int i = 2; i <= NumStages; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	// Stage 1: capture angle and its magnitude
	assign amag_in = s_axis_tdata[31] ? (~s_axis_tdata + 32'd1) : s_axis_tdata;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1    <= $signed(s_axis_tdata);
			amag_s1 <= amag_in;
		end
	end

	// Stage 2: scale magnitude by 1/(2*pi)
	always_ff @(posedge clk) begin
		if (en) begin
			a_s2     <= a_s1;
			qprod_s2 <= 62'(amag_s1) * 62'(INV_TWO_PI_Q32);
		end
	end

	// Stage 3: round quotient, subtract the multiple of 2*pi
	always_comb begin
		qrnd = {1'b0, qprod_s2} + (63'(1) << 55);
		qm   = qrnd[62:56];
		qtp  = 38'(qm) * 38'(TWO_PI_Q28);
		a16  = 39'(a_s2) <<< 4;
		yw   = a_s2[AngW-1] ? (a16 + $signed({1'b0, qtp})) : (a16 - $signed({1'b0, qtp}));
	end

	always_ff @(posedge clk) begin
		if (en) y_s3 <= yw[31:0];
	end

	// Stage 4: fold into [-pi/2, pi/2]
	always_comb begin
		fold  = 1'b0;
		yfold = y_s3;
		if (y_s3 > HALF_PI_Q28) begin
			fold  = 1'b1;
			yfold = PI_Q28 - y_s3;
		end else if (y_s3 < -HALF_PI_Q28) begin
			fold  = 1'b1;
			yfold = -PI_Q28 - y_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			yf_s4   <= yfold;
			flip_s4 <= fold;
		end
	end

	// Stage 5: rescale to Q30 and split sign and magnitude
	assign y30 = yf_s4 <<< 2;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[5].flip <= flip_s4;
			side_s[5].yneg <= y30[31];
			side_s[5].ymag <= MagW'(y30[31] ? -y30 : y30);
			for (int i = 6; i <= FinalStage; i++) side_s[i] <= side_s[i-1];
		end
	end

	// Stages 6 and 7: y squared, rounded to Q30
	assign sqrnd = {1'b0, sq_s6} + ((ProdW + 1)'(1) << 29);

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s6 <= ProdW'(side_s[5].ymag) * ProdW'(side_s[5].ymag);
			y2_s[HornerBase] <= XW'(sqrnd[ProdW:30]);
			for (int i = HornerBase + 1; i <= LaneDone - 2; i++) y2_s[i] <= y2_s[i-1];
		end
	end

	// Horner lanes for the sine and cosine polynomials
	assign sin_l[0] = '{neg: 1'b1, mag: SIN_C11_MAG};
	assign cos_l[0] = '{neg: 1'b1, mag: COS_C10_MAG};

	for (genvar k = 0; k < HornerSteps; k++) begin : g_horner
		scm_step u_sin (
			.clk     (clk),
			.en      (en),
			.lane_in (sin_l[k]),
			.x_in    (y2_s[HornerBase + 2 * k]),
			.coef    (SIN_COEF[k]),
			.lane_out(sin_l[k+1])
		);
		scm_step u_cos (
			.clk     (clk),
			.en      (en),
			.lane_in (cos_l[k]),
			.x_in    (y2_s[HornerBase + 2 * k]),
			.coef    (COS_COEF[k]),
			.lane_out(cos_l[k+1])
		);
	end

	// Final sine multiply by y; cosine waits alongside
	assign sfin_in.neg = sin_l[HornerSteps].neg ^ side_s[LaneDone].yneg;
	assign sfin_in.mag = sin_l[HornerSteps].mag;

	scm_step u_sin_final (
		.clk     (clk),
		.en      (en),
		.lane_in (sfin_in),
		.x_in    (side_s[LaneDone].ymag),
		.coef    ('0),
		.lane_out(sfin_out)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			cos_s18 <= cos_l[HornerSteps];
			cos_s19 <= cos_s18;
		end
	end

	// Stage 20: apply fold sign, saturate to plus or minus one
	always_comb begin
		smag = (sfin_out.mag > Q30_ONE) ? Q30_ONE : sfin_out.mag;
		cmag = (cos_s19.mag > Q30_ONE) ? Q30_ONE : cos_s19.mag;
		cneg = cos_s19.neg ^ side_s[FinalStage].flip;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sine_s20   <= sfin_out.neg ? OutW'(-smag) : OutW'(smag);
			cosine_s20 <= cneg ? OutW'(-cmag) : OutW'(cmag);
		end
	end

endmodule

>>> test/scm_checker.sv
`timescale 1ns / 100ps
// Result checker for the sine/cosine pipeline: watches both stream channels,
// predicts sine and cosine for every accepted angle and compares them in order.
// Depends on nothing but the port widths of sine_cosine_minimax.
module scm_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] angle
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [63:0] m_axis_tdata,   // [31:0] sine, [63:32] cosine
	output int          fail_count,
	output int          pending
);

	// Fixed-point constants of the reduction and the two polynomials
	localparam longint unsigned RECIP_TWO_PI_Q32 = 64'd683565276;
	localparam longint TWO_PI_Q4_28  = 64'sd1686629713;
	localparam longint PI_Q4_28      = 64'sd843314857;
	localparam longint HALF_PI_Q4_28 = 64'sd421657428;
	localparam longint UNIT_Q30      = 64'sd1073741824;

	localparam longint S11 = -64'sd26;
	localparam longint S9  = 64'sd2956;
	localparam longint S7  = -64'sd213040;
	localparam longint S5  = 64'sd8947846;
	localparam longint S3  = -64'sd178956974;

	localparam longint C10 = -64'sd280;
	localparam longint C8  = 64'sd26586;
	localparam longint C6  = -64'sd1491253;
	localparam longint C4  = 64'sd44739212;
	localparam longint C2  = -64'sd536870912;

	typedef struct packed {
		logic signed [31:0] cosine;
		logic signed [31:0] sine;
	} sincos_t;

	sincos_t sincos_q [$];

	// Q30 product with the magnitude rounded half away from zero
	function automatic longint q30_mul(longint x, longint z);
		bit neg;
		longint unsigned mx, mz, m;
		neg = (x < 0) != (z < 0);
		mx = (x < 0) ? -x : x;
		mz = (z < 0) ? -z : z;
		m = (mx * mz + (64'd1 << 29)) >> 30;
		return neg ? -longint'(m) : longint'(m);
	endfunction

	function automatic logic signed [31:0] clamp_unit(longint v);
		if (v > UNIT_Q30)
			return 32'(UNIT_Q30);
		if (v < -UNIT_Q30)
			return 32'(-UNIT_Q30);
		return 32'(v);
	endfunction

	function automatic sincos_t predict_sincos(logic signed [31:0] angle);
		longint a, turns, y, y30, y2, ps, pc;
		longint unsigned mag;
		bit folded;
		sincos_t r;
		a = angle;
		// Whole turns, rounded half away from zero
		mag = (a < 0) ? -a : a;
		turns = longint'((mag * RECIP_TWO_PI_Q32 + (64'd1 << 55)) >> 56);
		if (a < 0)
			turns = -turns;
		y = a * 16 - turns * TWO_PI_Q4_28;
		// Fold into [-pi/2, pi/2]; exactly on the fold point stays put
		folded = 1'b0;
		if (y > HALF_PI_Q4_28) begin
			y = PI_Q4_28 - y;
			folded = 1'b1;
		end else if (y < -HALF_PI_Q4_28) begin
			y = -PI_Q4_28 - y;
			folded = 1'b1;
		end
		y30 = y * 4;
		y2 = q30_mul(y30, y30);
		ps = S11;
		ps = q30_mul(ps, y2) + S9;
		ps = q30_mul(ps, y2) + S7;
		ps = q30_mul(ps, y2) + S5;
		ps = q30_mul(ps, y2) + S3;
		ps = q30_mul(ps, y2) + UNIT_Q30;
		r.sine = clamp_unit(q30_mul(ps, y30));
		pc = C10;
		pc = q30_mul(pc, y2) + C8;
		pc = q30_mul(pc, y2) + C6;
		pc = q30_mul(pc, y2) + C4;
		pc = q30_mul(pc, y2) + C2;
		pc = q30_mul(pc, y2) + UNIT_Q30;
		if (folded)
			pc = -pc;
		r.cosine = clamp_unit(pc);
		return r;
	endfunction

	task automatic report_fault(string what, logic [31:0] want, logic [31:0] got);
		$display("%0t: %s: expected %h, got %h", $realtime, what, want, got);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
	end

	// Compare each result with the oldest prediction, then queue the new request
	always @(posedge clk) begin
		sincos_t want, got;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				if (sincos_q.size() == 0) begin
					report_fault("result with no request", 32'h0, got.sine);
				end else begin
					want = sincos_q.pop_front();
					if (got.sine !== want.sine)
						report_fault("sine", want.sine, got.sine);
					if (got.cosine !== want.cosine)
						report_fault("cosine", want.cosine, got.cosine);
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				sincos_q.push_back(predict_sincos(s_axis_tdata));
			pending = sincos_q.size();
		end
	end

endmodule

>>> test/sine_cosine_minimax_tb.sv
`timescale 1ns / 100ps
// Top of the sine/cosine testbench: clock, reset, angle requests and result
// back-pressure. Depends on sine_cosine_minimax and scm_checker.
module sine_cosine_minimax_tb;

	localparam int LatencyCycles = 20;
	localparam int RandomItems   = 650;
	localparam int BurstStart    = 300;
	localparam int BurstItems    = 80;
	localparam int LongHold      = 150;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;
	int          fail_count;
	int          pending;
	bit          burst_on = 1'b0;
	bit          held = 1'b0;

	// Angles around zero, the range ends, the fold points and the turn boundaries
	logic [31:0] corner_angles [23] = '{
		32'd0, 32'd1, -32'sd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h5555_5555,
		32'hAAAA_AAAA, 32'd26353589, 32'd26353590, -32'sd26353589, -32'sd26353590,
		32'd52707179, -32'sd52707179, 32'd1291325874, 32'd1291325873,
		32'd1291325875, -32'sd1291325874, 32'd395303839, -32'sd395303839,
		32'd105414358, 32'd158121536, 32'd158121537, 32'd79060768
	};

	sine_cosine_minimax u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	scm_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hold one request on the bus until accepted, after an optional gap
	task automatic send_angle(logic [31:0] angle, int gap);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= angle;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	// Full range, one turn around zero, or close to a multiple of pi/2
	function automatic logic [31:0] pick_angle();
		longint k, a;
		case ($urandom_range(0, 3))
			0, 1: a = $urandom;
			2: a = longint'($urandom_range(0, 105414358)) - 64'sd52707179;
			default: begin
				k = longint'($urandom_range(0, 162)) - 64'sd81;
				a = (k * 64'sd1686629713) / 64 + longint'($urandom_range(0, 256)) - 128;
			end
		endcase
		return a[31:0];
	endfunction

	// Requests: corners, a drain, random angles with a burst, then the verdict
	initial begin
		bit fast;
		int gap;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (corner_angles[i])
			send_angle(corner_angles[i], $urandom_range(0, 2));
		s_axis_tvalid <= 1'b0;
		wait (pending == 0);
		@(posedge clk);
		fast = 1'b0;
		for (int n = 0; n < RandomItems; n++) begin
			if (n % 50 == 0)
				fast = ($urandom_range(0, 2) == 0);
			burst_on = (n >= BurstStart && n < BurstStart + BurstItems);
			gap = (fast || burst_on) ? 0 : $urandom_range(0, 7);
			send_angle(pick_angle(), gap);
		end
		s_axis_tvalid <= 1'b0;
		burst_on = 1'b0;
		wait (pending == 0);
		repeat (LatencyCycles + 10) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Results: random stall before each, one long hold while the burst runs
	initial begin
		int stall;
		wait (arst_n);
		forever begin
			stall = $urandom_range(0, 7);
			if (burst_on && !held) begin
				stall = LongHold;
				held = 1'b1;
			end
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
		end
	end

	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
